[rtl/first_fit_heap_allocator_assert.svh]
// Assertion macros for the first-fit heap allocator.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FFHA_ASSERT_SAME(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define FFHA_ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define FFHA_ASSERT_SAME(lbl, a, c, msg)
`define FFHA_ASSERT_NEXT(lbl, a, c, msg)
`endif
`endif

[rtl/ffha_pkg.sv]
`timescale 1ns / 1ps
package ffha_pkg;

  localparam int HEAP_BYTES_DEF = 65536;
  localparam int LINK_W = 15;
  localparam int SIZE_W = 17;
  localparam logic [LINK_W-1:0] NIL = 15'h7FFF;
  localparam logic [SIZE_W-1:0] HDR_BYTES = 17'd12;
  localparam logic [SIZE_W-1:0] MIN_REGION = 17'd1024;
  localparam logic [SIZE_W-1:0] USED_BIT = 17'h00001;
  localparam logic [SIZE_W-1:0] REGION_RST = 17'h10000;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NOFIT = 3'd1;
  localparam logic [2:0] ST_MISAL = 3'd2;
  localparam logic [2:0] ST_FREED = 3'd3;
  localparam logic [2:0] ST_NOBLK = 3'd4;

  typedef struct packed {
    logic              mark;
    logic [SIZE_W-1:0] pre;
    logic [SIZE_W-1:0] cur;
    logic [LINK_W-1:0] nxt;
    logic [LINK_W-1:0] prv;
  } entry_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_CLR, OP_INIT0, OP_INIT1, OP_A_START, OP_RD_IT,
    OP_A_TEST, OP_RD_P, OP_WR_P, OP_HEAD_Q, OP_RD_Q, OP_WR_Q, OP_TAIL_P,
    OP_A_WHOLE, OP_A_SPLIT, OP_A_NEW, OP_RD_TGT, OP_WR_PRE, OP_RD_HEAD,
    OP_WR_HEADPREV, OP_PUSH_EMPTY, OP_F_START, OP_RD_H, OP_F_CHK,
    OP_F_NMERGE, OP_F_NOMERGE, OP_F_G, OP_WR_GCUR, OP_F_PUSH
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic heap_ok;
    logic it_nil;
    logic fit;
    logic p_ok;
    logic q_ok;
    logic tgt_ok;
    logic small_rest;
    logic early_bad;
    logic chk_bad;
    logic n_free;
    logic merge_prev;
    logic head_ok;
    logic tail_ok;
  } flags_t;

endpackage

[rtl/ffha_datapath.sv]
`timescale 1ns / 1ps
module ffha_datapath #(
  parameter int HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ffha_pkg::cmd_t               cmd,
  output ffha_pkg::flags_t             flags,
  input  logic                         cfg_wr,
  input  logic [ffha_pkg::SIZE_W-1:0]  cfg_data,
  input  logic [15:0]                  req_bytes,
  input  logic [15:0]                  block_addr,
  output logic [2:0]                   status,
  output logic [15:0]                  payload_addr
);
  import ffha_pkg::*;

  localparam int SW = ((HEAP_BYTES < 65536) ? HEAP_BYTES : 65536) / 4;
  localparam int AW = $clog2(SW);
  localparam logic [LINK_W-1:0] SW_L = LINK_W'(SW);
  localparam logic [17:0] SW_T = 18'(SW);
  localparam logic [SIZE_W-1:0] EMAX = SIZE_W'(SW * 4);

  entry_t mem [SW];
  entry_t rdata_r;
  logic re, we;
  logic [AW-1:0] ra, wa;
  entry_t wd;

  logic [SIZE_W-1:0] region_r;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [LINK_W-1:0] head_r, head_nxt, tail_r, tail_nxt, tailh_r, tailh_nxt;
  logic [LINK_W-1:0] it_r, it_nxt, p_r, p_nxt, q_r, q_nxt;
  logic [AW-1:0] h_r, h_nxt, x_r, x_nxt;
  entry_t e_r, e_nxt;
  logic [SIZE_W-1:0] need_r, need_nxt, val_r, val_nxt;
  logic [17:0] tgt_r, tgt_nxt;
  logic [2:0] stat_r, stat_nxt;
  logic [15:0] addr_r, addr_nxt, req_r, req_nxt, baddr_r, baddr_nxt;

  logic [SIZE_W-1:0] endv, endc, rest, hsub;
  logic heap_ok;
  logic [17:0] off;
  logic [2:0] early, chk;

  function automatic logic [17:0] hop(input logic [AW-1:0] i, input logic [SIZE_W-1:0] sz);
    return 18'(i) + 18'd3 + 18'(sz[SIZE_W-1:2]);
  endfunction

  always_comb begin
    endv = {region_r[SIZE_W-1:2], 2'b00};
    endc = (endv > EMAX) ? EMAX : endv;
    heap_ok = endc > MIN_REGION;
    rest = (e_r.cur & 17'h1FFFC) - need_r;
    off = 18'd3 + 18'(e_r.pre[SIZE_W-1:2]);
    hsub = ({1'b0, baddr_r} - HDR_BYTES) >> 2;
    if (!heap_ok) begin
      early = ST_NOBLK;
    end else if (baddr_r[1:0] != 2'b00) begin
      early = ST_MISAL;
    end else if (baddr_r < 16'd12 || hsub >= SIZE_W'(SW)) begin
      early = ST_NOBLK;
    end else begin
      early = ST_OK;
    end
    if (!rdata_r.mark || LINK_W'(h_r) == tailh_r) begin
      chk = ST_NOBLK;
    end else if (!rdata_r.cur[0]) begin
      chk = ST_FREED;
    end else begin
      chk = ST_OK;
    end
  end

  always_comb begin
    flags.clr_last = clr_r == AW'(SW - 1);
    flags.heap_ok = heap_ok;
    flags.it_nil = it_r >= SW_L;
    flags.fit = rdata_r.cur[1:0] == 2'b00 && rdata_r.cur >= need_r;
    flags.p_ok = p_r < SW_L;
    flags.q_ok = q_r < SW_L;
    flags.tgt_ok = tgt_r < SW_T;
    flags.small_rest = rest <= HDR_BYTES;
    flags.early_bad = early != ST_OK;
    flags.chk_bad = chk != ST_OK;
    flags.n_free = !rdata_r.cur[0];
    flags.merge_prev = !e_r.pre[0] && off <= 18'(h_r);
    flags.head_ok = head_r < SW_L;
    flags.tail_ok = tail_r < SW_L;
  end

  always_comb begin
    re = 1'b0;
    we = 1'b0;
    ra = h_r;
    wa = h_r;
    wd = e_r;
    clr_nxt = clr_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    tailh_nxt = tailh_r;
    it_nxt = it_r;
    p_nxt = p_r;
    q_nxt = q_r;
    h_nxt = h_r;
    x_nxt = x_r;
    e_nxt = e_r;
    need_nxt = need_r;
    val_nxt = val_r;
    tgt_nxt = tgt_r;
    stat_nxt = stat_r;
    addr_nxt = addr_r;
    req_nxt = req_r;
    baddr_nxt = baddr_r;
    unique case (cmd.op)
      OP_LATCH: begin
        req_nxt = req_bytes;
        baddr_nxt = block_addr;
      end
      OP_CLR: begin
        we = 1'b1;
        wa = clr_r;
        wd = '0;
        clr_nxt = clr_r + AW'(1);
      end
      OP_INIT0: begin
        head_nxt = heap_ok ? '0 : NIL;
        tail_nxt = heap_ok ? '0 : NIL;
        tailh_nxt = heap_ok ? LINK_W'((endc - HDR_BYTES) >> 2) : NIL;
        we = heap_ok;
        wa = '0;
        wd = '{mark: 1'b1, pre: USED_BIT, cur: endc - 17'd24, nxt: NIL, prv: NIL};
      end
      OP_INIT1: begin
        we = heap_ok;
        wa = tailh_r[AW-1:0];
        wd = '{mark: 1'b1, pre: endc - 17'd24, cur: USED_BIT, nxt: '0, prv: '0};
      end
      OP_A_START: begin
        need_nxt = ({1'b0, req_r} + 17'd3) & 17'h1FFFC;
        it_nxt = head_r;
        stat_nxt = ST_NOFIT;
        addr_nxt = '0;
      end
      OP_RD_IT: begin
        re = 1'b1;
        ra = it_r[AW-1:0];
      end
      OP_A_TEST: begin
        if (flags.fit) begin
          e_nxt = rdata_r;
          h_nxt = it_r[AW-1:0];
          p_nxt = rdata_r.prv;
          q_nxt = rdata_r.nxt;
        end else begin
          it_nxt = rdata_r.nxt;
        end
      end
      OP_RD_P: begin
        re = 1'b1;
        ra = p_r[AW-1:0];
      end
      OP_WR_P: begin
        we = 1'b1;
        wa = p_r[AW-1:0];
        wd = rdata_r;
        wd.nxt = q_r;
      end
      OP_HEAD_Q: head_nxt = q_r;
      OP_RD_Q: begin
        re = 1'b1;
        ra = q_r[AW-1:0];
      end
      OP_WR_Q: begin
        we = 1'b1;
        wa = q_r[AW-1:0];
        wd = rdata_r;
        wd.prv = p_r;
      end
      OP_TAIL_P: tail_nxt = p_r;
      OP_A_WHOLE: begin
        e_nxt.cur = e_r.cur | USED_BIT;
        we = 1'b1;
        wd = e_nxt;
        val_nxt = e_nxt.cur;
        tgt_nxt = hop(h_r, e_nxt.cur);
        stat_nxt = ST_OK;
        addr_nxt = 16'((18'(h_r) << 2) + 18'd12);
      end
      OP_A_SPLIT: begin
        e_nxt.cur = need_r | USED_BIT;
        we = 1'b1;
        wd = e_nxt;
        x_nxt = AW'(hop(h_r, need_r));
        val_nxt = rest - HDR_BYTES;
        stat_nxt = ST_OK;
        addr_nxt = 16'((18'(h_r) << 2) + 18'd12);
      end
      OP_A_NEW: begin
        we = 1'b1;
        wa = x_r;
        wd = '{mark: 1'b1, pre: need_r | USED_BIT, cur: val_r, nxt: head_r, prv: NIL};
        tgt_nxt = hop(x_r, val_r);
      end
      OP_RD_TGT: begin
        re = 1'b1;
        ra = tgt_r[AW-1:0];
      end
      OP_WR_PRE: begin
        we = 1'b1;
        wa = tgt_r[AW-1:0];
        wd = rdata_r;
        wd.pre = val_r;
      end
      OP_RD_HEAD: begin
        re = 1'b1;
        ra = head_r[AW-1:0];
      end
      OP_WR_HEADPREV: begin
        we = 1'b1;
        wa = head_r[AW-1:0];
        wd = rdata_r;
        wd.prv = LINK_W'(x_r);
        head_nxt = LINK_W'(x_r);
      end
      OP_PUSH_EMPTY: begin
        tail_nxt = LINK_W'(x_r);
        head_nxt = LINK_W'(x_r);
      end
      OP_F_START: begin
        stat_nxt = early;
        addr_nxt = '0;
        h_nxt = AW'(hsub);
      end
      OP_RD_H: re = 1'b1;
      OP_F_CHK: begin
        e_nxt = rdata_r;
        stat_nxt = chk;
        tgt_nxt = hop(h_r, rdata_r.cur);
      end
      OP_F_NMERGE: begin
        val_nxt = (e_r.cur & 17'h1FFFC) + HDR_BYTES + rdata_r.cur;
        p_nxt = rdata_r.prv;
        q_nxt = rdata_r.nxt;
        e_nxt.cur = val_nxt;
        we = 1'b1;
        wd = e_nxt;
        tgt_nxt = hop(h_r, val_nxt);
      end
      OP_F_NOMERGE: begin
        val_nxt = e_r.cur & 17'h1FFFC;
        e_nxt.cur = val_nxt;
        we = 1'b1;
        wd = e_nxt;
        tgt_nxt = hop(h_r, val_nxt);
      end
      OP_F_G: begin
        x_nxt = AW'(18'(h_r) - off);
        re = 1'b1;
        ra = x_nxt;
        val_nxt = e_r.cur + e_r.pre + HDR_BYTES;
      end
      OP_WR_GCUR: begin
        we = 1'b1;
        wa = x_r;
        wd = rdata_r;
        wd.cur = val_r;
        tgt_nxt = hop(x_r, val_r);
      end
      OP_F_PUSH: begin
        e_nxt.nxt = head_r;
        e_nxt.prv = NIL;
        we = 1'b1;
        wd = e_nxt;
        x_nxt = h_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata_r <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_r <= REGION_RST;
      clr_r <= '0;
      head_r <= NIL;
      tail_r <= NIL;
      tailh_r <= NIL;
    end else begin
      if (cfg_wr) begin
        region_r <= cfg_data;
        clr_r <= '0;
      end else begin
        clr_r <= clr_nxt;
      end
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      tailh_r <= tailh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    it_r <= it_nxt;
    p_r <= p_nxt;
    q_r <= q_nxt;
    h_r <= h_nxt;
    x_r <= x_nxt;
    e_r <= e_nxt;
    need_r <= need_nxt;
    val_r <= val_nxt;
    tgt_r <= tgt_nxt;
    stat_r <= stat_nxt;
    addr_r <= addr_nxt;
    req_r <= req_nxt;
    baddr_r <= baddr_nxt;
  end

  assign status = stat_r;
  assign payload_addr = addr_r;

endmodule

[rtl/ffha_ctrl.sv]
`timescale 1ns / 1ps
module ffha_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             in_func,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  output logic             cfg_wr,
  output logic             busy,
  output logic             done,
  output ffha_pkg::cmd_t   cmd,
  input  ffha_pkg::flags_t flags
);
  import ffha_pkg::*;

  typedef enum logic [24:0] {
    S_IDLE     = 25'd1 << 0,
    S_CLR      = 25'd1 << 1,
    S_INIT0    = 25'd1 << 2,
    S_INIT1    = 25'd1 << 3,
    S_A_START  = 25'd1 << 4,
    S_A_LOOK   = 25'd1 << 5,
    S_A_TEST   = 25'd1 << 6,
    S_RM_P     = 25'd1 << 7,
    S_RM_PW    = 25'd1 << 8,
    S_RM_Q     = 25'd1 << 9,
    S_RM_QW    = 25'd1 << 10,
    S_A_DECIDE = 25'd1 << 11,
    S_A_NEW    = 25'd1 << 12,
    S_PRE_R    = 25'd1 << 13,
    S_PRE_W    = 25'd1 << 14,
    S_PUSH_H   = 25'd1 << 15,
    S_PUSH_W   = 25'd1 << 16,
    S_F_START  = 25'd1 << 17,
    S_F_RDH    = 25'd1 << 18,
    S_F_CHK    = 25'd1 << 19,
    S_F_NRD    = 25'd1 << 20,
    S_F_NCHK   = 25'd1 << 21,
    S_F_LAST   = 25'd1 << 22,
    S_G_W      = 25'd1 << 23,
    S_DONE     = 25'd1 << 24
  } state_t;

  typedef enum logic [2:0] {
    CX_AWHOLE, CX_ASPLIT, CX_FH, CX_FHM, CX_FG
  } ctx_t;

  state_t state_r, state_nxt, pre_ret, rm_ret;
  ctx_t ctx_r, ctx_nxt;
  logic func_r, func_nxt;

  assign cfg_ready = (state_r == S_IDLE && !start) || state_r == S_CLR;
  assign cfg_wr = cfg_valid && cfg_ready;
  assign busy = state_r != S_IDLE;
  assign done = state_r == S_DONE;

  always_comb begin
    unique case (ctx_r)
      CX_ASPLIT: pre_ret = S_PUSH_H;
      CX_FH:     pre_ret = S_F_LAST;
      CX_FHM:    pre_ret = S_RM_P;
      default:   pre_ret = S_DONE;
    endcase
    rm_ret = func_r ? S_F_LAST : S_A_DECIDE;
  end

  always_comb begin
    state_nxt = state_r;
    ctx_nxt = ctx_r;
    func_nxt = func_r;
    cmd.op = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op = OP_LATCH;
          func_nxt = in_func;
          state_nxt = in_func ? S_F_START : S_A_START;
        end else if (cfg_wr) begin
          state_nxt = S_CLR;
        end
      end
      S_CLR: begin
        cmd.op = OP_CLR;
        if (!cfg_wr && flags.clr_last) begin
          state_nxt = S_INIT0;
        end
      end
      S_INIT0: begin
        cmd.op = OP_INIT0;
        state_nxt = S_INIT1;
      end
      S_INIT1: begin
        cmd.op = OP_INIT1;
        state_nxt = S_IDLE;
      end
      S_A_START: begin
        cmd.op = OP_A_START;
        state_nxt = flags.heap_ok ? S_A_LOOK : S_DONE;
      end
      S_A_LOOK: begin
        if (flags.it_nil) begin
          state_nxt = S_DONE;
        end else begin
          cmd.op = OP_RD_IT;
          state_nxt = S_A_TEST;
        end
      end
      S_A_TEST: begin
        cmd.op = OP_A_TEST;
        state_nxt = flags.fit ? S_RM_P : S_A_LOOK;
      end
      S_RM_P: begin
        if (flags.p_ok) begin
          cmd.op = OP_RD_P;
          state_nxt = S_RM_PW;
        end else begin
          cmd.op = OP_HEAD_Q;
          state_nxt = S_RM_Q;
        end
      end
      S_RM_PW: begin
        cmd.op = OP_WR_P;
        state_nxt = S_RM_Q;
      end
      S_RM_Q: begin
        if (flags.q_ok) begin
          cmd.op = OP_RD_Q;
          state_nxt = S_RM_QW;
        end else begin
          cmd.op = OP_TAIL_P;
          state_nxt = rm_ret;
        end
      end
      S_RM_QW: begin
        cmd.op = OP_WR_Q;
        state_nxt = rm_ret;
      end
      S_A_DECIDE: begin
        if (flags.small_rest) begin
          cmd.op = OP_A_WHOLE;
          ctx_nxt = CX_AWHOLE;
          state_nxt = S_PRE_R;
        end else begin
          cmd.op = OP_A_SPLIT;
          state_nxt = S_A_NEW;
        end
      end
      S_A_NEW: begin
        cmd.op = OP_A_NEW;
        ctx_nxt = CX_ASPLIT;
        state_nxt = S_PRE_R;
      end
      S_PRE_R: begin
        if (flags.tgt_ok) begin
          cmd.op = OP_RD_TGT;
          state_nxt = S_PRE_W;
        end else begin
          state_nxt = pre_ret;
        end
      end
      S_PRE_W: begin
        cmd.op = OP_WR_PRE;
        state_nxt = pre_ret;
      end
      S_PUSH_H: begin
        if (flags.head_ok) begin
          cmd.op = OP_RD_HEAD;
          state_nxt = S_PUSH_W;
        end else begin
          cmd.op = OP_PUSH_EMPTY;
          state_nxt = S_DONE;
        end
      end
      S_PUSH_W: begin
        cmd.op = OP_WR_HEADPREV;
        state_nxt = S_DONE;
      end
      S_F_START: begin
        cmd.op = OP_F_START;
        state_nxt = flags.early_bad ? S_DONE : S_F_RDH;
      end
      S_F_RDH: begin
        cmd.op = OP_RD_H;
        state_nxt = S_F_CHK;
      end
      S_F_CHK: begin
        cmd.op = OP_F_CHK;
        state_nxt = flags.chk_bad ? S_DONE : S_F_NRD;
      end
      S_F_NRD: begin
        if (flags.tgt_ok) begin
          cmd.op = OP_RD_TGT;
          state_nxt = S_F_NCHK;
        end else begin
          cmd.op = OP_F_NOMERGE;
          ctx_nxt = CX_FH;
          state_nxt = S_PRE_R;
        end
      end
      S_F_NCHK: begin
        if (flags.n_free) begin
          cmd.op = OP_F_NMERGE;
          ctx_nxt = CX_FHM;
        end else begin
          cmd.op = OP_F_NOMERGE;
          ctx_nxt = CX_FH;
        end
        state_nxt = S_PRE_R;
      end
      S_F_LAST: begin
        if (flags.merge_prev) begin
          cmd.op = OP_F_G;
          state_nxt = S_G_W;
        end else begin
          cmd.op = OP_F_PUSH;
          state_nxt = S_PUSH_H;
        end
      end
      S_G_W: begin
        cmd.op = OP_WR_GCUR;
        ctx_nxt = CX_FG;
        state_nxt = S_PRE_R;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      ctx_r <= CX_AWHOLE;
      func_r <= 1'b0;
    end else begin
      state_r <= (cfg_wr && state_r == S_CLR) ? S_CLR : state_nxt;
      ctx_r <= ctx_nxt;
      func_r <= func_nxt;
    end
  end

endmodule

[rtl/first_fit_heap_allocator.sv]
`timescale 1ns / 1ps
// Allocate walks the free list from its head until an entry fits, and reports no fit
// when none does or there is no heap. One request is in work at a time, the next is
// accepted in the cycle after the result strobe, and the receiver cannot stall. Reset
// and every configuration write start a clearing pass over the header memory, during
// which busy is high.
`include "first_fit_heap_allocator_assert.svh"
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_func,
  input  logic [15:0]                 in_req_bytes,
  input  logic [15:0]                 in_block_addr,
  output logic                        out_strobe,
  output logic [2:0]                  out_status,
  output logic [15:0]                 out_payload_addr,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ffha_pkg::SIZE_W-1:0] cfg_region_bytes
);
  import ffha_pkg::*;

  cmd_t cmd;
  flags_t flags;
  logic cfg_wr;

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_func   (in_func),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_wr    (cfg_wr),
    .busy      (busy),
    .done      (out_strobe),
    .cmd       (cmd),
    .flags     (flags)
  );

  ffha_datapath #(
    .HEAP_BYTES (HEAP_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .flags        (flags),
    .cfg_wr       (cfg_wr),
    .cfg_data     (cfg_region_bytes),
    .req_bytes    (in_req_bytes),
    .block_addr   (in_block_addr),
    .status       (out_status),
    .payload_addr (out_payload_addr)
  );

  `FFHA_ASSERT_NEXT(a_one_strobe, out_strobe, !out_strobe, "result word repeated")
  `FFHA_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted word did not start work")
  `FFHA_ASSERT_SAME(a_fail_zero, out_strobe && out_status != ST_OK, out_payload_addr == 16'd0, "address on failure")
  `FFHA_ASSERT_SAME(a_list_ends, !busy, flags.head_ok == flags.tail_ok, "list ends disagree")

endmodule
